[rtl/core/obfr_pkg.sv]
package obfr_pkg;

    // Longest frame body (address, command and payload characters) accepted.
    localparam int MAX_FRAME_CHARS = 256;

    // Character counter holds 0 up to MAX_FRAME_CHARS.
    localparam int CNT_W = $clog2(MAX_FRAME_CHARS + 1);

    // Width for the length check: three times the group count and
    // expected_length plus three must both fit.
    localparam int CMP_W = (CNT_W + 1 > 9) ? CNT_W + 1 : 9;

    // Characters with a fixed meaning on the line.
    localparam logic [7:0] CH_START  = 8'h23;
    localparam logic [7:0] CH_OFFSET = 8'h3D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;

    // Configuration register indexes.
    localparam logic [1:0] REG_DEVICE_ADDRESS  = 2'd0;
    localparam logic [1:0] REG_COMMAND_CODE    = 2'd1;
    localparam logic [1:0] REG_EXPECTED_LENGTH = 2'd2;

    // Frame status codes.
    localparam logic [2:0] ST_GOOD      = 3'd0;
    localparam logic [2:0] ST_BAD_START = 3'd1;
    localparam logic [2:0] ST_BAD_ADDR  = 3'd2;
    localparam logic [2:0] ST_BAD_CMD   = 3'd3;
    localparam logic [2:0] ST_OVERFLOW  = 3'd4;
    localparam logic [2:0] ST_CHECKSUM  = 3'd5;
    localparam logic [2:0] ST_LENGTH    = 3'd6;

    // Receiver phase.
    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_ADDRESS = 2'd1,
        PH_COMMAND = 2'd2,
        PH_PAYLOAD = 2'd3
    } phase_t;

    // One result item (the last flag is derived at the output).
    typedef struct packed {
        logic       is_status;
        logic [7:0] data_byte;
        logic [2:0] frame_status;
    } res_t;

    // All results caused by one character.
    typedef struct packed {
        logic [1:0]     count;
        res_t [2:0]     item;
    } burst_t;

    // One configuration write.
    typedef struct packed {
        logic       valid;
        logic [1:0] index;
        logic [7:0] data;
    } cfg_wr_t;

endpackage

[rtl/core/obfr_parser.sv]
module obfr_parser
    import obfr_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  cfg_wr_t      cfg_wr,
    input  logic         in_fire,
    input  logic [7:0]   in_char,
    output burst_t       burst
);

    // Configuration registers.
    logic [7:0]       dev_addr_reg;
    logic [7:0]       cmd_code_reg;
    logic [7:0]       exp_len_reg;

    // Frame state.
    phase_t           phase_reg, phase_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [11:0]      sum_reg, sum_next;
    logic [7:0]       held_reg [2];
    logic [7:0]       held_next [2];
    logic [7:0]       group_reg [3];
    logic [7:0]       group_next [3];
    logic [7:0]       bytes_reg, bytes_next;
    logic             use_cr_reg, use_cr_next;

    // Working values.
    logic [7:0]       term;
    logic [7:0]       sum_hi_ch;
    logic [7:0]       sum_lo_ch;
    logic [CNT_W-1:0] groups;
    logic [CMP_W-1:0] total;
    logic [CMP_W-1:0] exp_wide;
    logic [2:0]       verdict;
    logic [23:0]      decoded;
    logic [1:0]       n_emit;

    // Four offset digits give three bytes, most significant bits first.
    function automatic logic [23:0] decode_group(input logic [7:0] c0, input logic [7:0] c1,
                                                 input logic [7:0] c2, input logic [7:0] c3);
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] e;
        logic [7:0] d;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        a  = c0 - CH_OFFSET;
        b  = c1 - CH_OFFSET;
        e  = c2 - CH_OFFSET;
        d  = c3 - CH_OFFSET;
        b0 = {a[5:0], 2'b00} | {4'b0000, b[7:4]};
        b1 = {b[3:0], 4'b0000} | {2'b00, e[7:2]};
        b2 = {e[1:0], 6'b000000} | d;
        return {b2, b1, b0};
    endfunction

    // Configuration writes; indexes beyond the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_addr_reg <= 8'd98;
            cmd_code_reg <= 8'd68;
            exp_len_reg  <= 8'd0;
        end
        else if (cfg_wr.valid)
        begin
            unique case (cfg_wr.index)
                REG_DEVICE_ADDRESS:  dev_addr_reg <= cfg_wr.data;
                REG_COMMAND_CODE:    cmd_code_reg <= cfg_wr.data;
                REG_EXPECTED_LENGTH: exp_len_reg  <= cfg_wr.data;
                default:             ;
            endcase
        end
    end

    // Frame verdict at the terminator: checksum first, then length.
    always_comb
    begin
        sum_hi_ch = CH_OFFSET + {2'b00, sum_reg[11:6]};
        sum_lo_ch = CH_OFFSET + {2'b00, sum_reg[5:0]};
        groups    = (cnt_reg - CNT_W'(4)) >> 2;
        total     = CMP_W'({groups, 1'b0}) + CMP_W'(groups);
        exp_wide  = CMP_W'(exp_len_reg);
        if (cnt_reg < CNT_W'(4))
            verdict = ST_CHECKSUM;
        else if (held_reg[0] != sum_hi_ch || held_reg[1] != sum_lo_ch)
            verdict = ST_CHECKSUM;
        else if (total >= exp_wide && total < exp_wide + CMP_W'(3))
            verdict = ST_GOOD;
        else
            verdict = ST_LENGTH;
    end

    // Next state and results for the character in the input register.
    always_comb
    begin
        phase_next    = phase_reg;
        cnt_next      = cnt_reg;
        sum_next      = sum_reg;
        held_next     = held_reg;
        group_next    = group_reg;
        bytes_next    = bytes_reg;
        use_cr_next   = use_cr_reg;
        burst         = '0;
        n_emit        = 2'd0;
        term          = use_cr_reg ? CH_CR : CH_LF;
        decoded       = decode_group(group_reg[0], group_reg[1], group_reg[2], held_reg[0]);

        if (in_fire)
        begin
            unique case (phase_reg)
                PH_IDLE:
                begin
                    if (in_char == CH_START)
                    begin
                        phase_next = PH_ADDRESS;
                        cnt_next   = '0;
                        sum_next   = 12'(CH_START);
                        bytes_next = 8'd0;
                    end
                    else
                    begin
                        burst.count             = 2'd1;
                        burst.item[0].is_status = 1'b1;
                        burst.item[0].frame_status = ST_BAD_START;
                    end
                end
                PH_ADDRESS:
                begin
                    if (in_char == dev_addr_reg)
                    begin
                        phase_next = PH_COMMAND;
                        cnt_next   = CNT_W'(1);
                        sum_next   = sum_reg + {4'b0000, in_char};
                    end
                    else
                    begin
                        phase_next              = PH_IDLE;
                        burst.count             = 2'd1;
                        burst.item[0].is_status = 1'b1;
                        burst.item[0].frame_status = ST_BAD_ADDR;
                    end
                end
                PH_COMMAND:
                begin
                    if (in_char == cmd_code_reg)
                    begin
                        phase_next = PH_PAYLOAD;
                        cnt_next   = CNT_W'(2);
                        sum_next   = sum_reg + {4'b0000, in_char};
                    end
                    else
                    begin
                        phase_next              = PH_IDLE;
                        burst.count             = 2'd1;
                        burst.item[0].is_status = 1'b1;
                        burst.item[0].frame_status = ST_BAD_CMD;
                    end
                end
                PH_PAYLOAD:
                begin
                    if (in_char == term)
                    begin
                        phase_next              = PH_IDLE;
                        burst.count             = 2'd1;
                        burst.item[0].is_status = 1'b1;
                        burst.item[0].frame_status = verdict;
                    end
                    else if (cnt_reg >= CNT_W'(MAX_FRAME_CHARS))
                    begin
                        phase_next              = PH_IDLE;
                        use_cr_next             = ~use_cr_reg;
                        burst.count             = 2'd1;
                        burst.item[0].is_status = 1'b1;
                        burst.item[0].frame_status = ST_OVERFLOW;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + CNT_W'(1);
                        if (cnt_reg < CNT_W'(4))
                        begin
                            // The first two payload characters only fill the holding pair.
                            held_next[cnt_reg[0]] = in_char;
                        end
                        else
                        begin
                            // The oldest held character is known not to be checksum.
                            held_next[0] = held_reg[1];
                            held_next[1] = in_char;
                            sum_next     = sum_reg + {4'b0000, held_reg[0]};
                            case (cnt_reg[1:0])
                                2'd0:    group_next[0] = held_reg[0];
                                2'd1:    group_next[1] = held_reg[0];
                                2'd2:    group_next[2] = held_reg[0];
                                default:
                                begin
                                    // Group complete: emit bytes up to the expected length.
                                    for (int i = 0; i < 3; i++)
                                    begin
                                        if ({1'b0, bytes_reg} + 9'(i) < {1'b0, exp_len_reg})
                                        begin
                                            burst.item[i].data_byte = decoded[8*i +: 8];
                                            n_emit = n_emit + 2'd1;
                                        end
                                    end
                                    burst.count = n_emit;
                                    bytes_next  = bytes_reg + {6'b000000, n_emit};
                                end
                            endcase
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            cnt_reg      <= '0;
            sum_reg      <= '0;
            held_reg[0]  <= '0;
            held_reg[1]  <= '0;
            group_reg[0] <= '0;
            group_reg[1] <= '0;
            group_reg[2] <= '0;
            bytes_reg    <= '0;
            use_cr_reg   <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            cnt_reg    <= cnt_next;
            sum_reg    <= sum_next;
            held_reg   <= held_next;
            group_reg  <= group_next;
            bytes_reg  <= bytes_next;
            use_cr_reg <= use_cr_next;
        end
    end

endmodule

[rtl/core/obfr_outbuf.sv]
module obfr_outbuf
    import obfr_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   load,
    input  burst_t burst,
    input  logic   pop,
    output logic   can_load,
    output logic   head_valid,
    output logic   head_last,
    output res_t   head
);

    // Holds the results of one character; entry 0 is the head.
    res_t       ent_reg [3];
    res_t       ent_next [3];
    logic [1:0] cnt_reg, cnt_next;

    // A new burst may land once the buffer is empty or its last beat leaves now.
    assign can_load   = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && pop);
    assign head_valid = (cnt_reg != 2'd0);
    assign head_last  = (cnt_reg == 2'd1);
    assign head       = ent_reg[0];

    // Shift out on a taken beat, overwrite on a load.
    always_comb
    begin
        ent_next = ent_reg;
        cnt_next = cnt_reg;
        if (pop)
        begin
            ent_next[0] = ent_reg[1];
            ent_next[1] = ent_reg[2];
            cnt_next    = cnt_reg - 2'd1;
        end
        if (load)
        begin
            ent_next[0] = burst.item[0];
            ent_next[1] = burst.item[1];
            ent_next[2] = burst.item[2];
            cnt_next    = burst.count;
        end
    end

    // Count register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else
            cnt_reg <= cnt_next;
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
    end

endmodule

[rtl/core/offset_base64_frame_receiver.sv]
// Channel   Direction  Signals                     Contents
// s_axis    in         s_tvalid/s_tready/s_tdata   one received character
// m_axis    out        m_tvalid/m_tready/m_t*      decoded byte or frame status
// cfg       in         cfg_valid/cfg_ready/...     register index and write data
//
// A character waits in the input register, then its results (none to three) are loaded
// into the output buffer together and leave one beat per cycle while m_tready is high.
// A character that releases three decoded bytes holds the output until all three are taken;
// the next character is processed in the cycle its last beat is taken.
// The output buffer is three entries deep; cfg_ready is always high.
// Reset clears the phase, counters, terminator choice and registers to their defaults.
// A stall on m_tready holds the buffer and, once the input register is full, s_tready.
module offset_base64_frame_receiver
    import obfr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] rx_char
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [7:0] data_byte, [10:8] frame_status, [15:11] zero
    output logic        m_tuser,    // [0] is_status
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    logic       pend_valid_reg;
    logic [7:0] pend_char_reg;
    logic       fire;
    logic       can_load;
    logic       pop;
    logic       head_valid;
    logic       head_last;
    res_t       head;
    burst_t     burst;
    cfg_wr_t    cfg_wr;

    assign cfg_ready    = 1'b1;
    assign cfg_wr.valid = cfg_valid;
    assign cfg_wr.index = cfg_index;
    assign cfg_wr.data  = cfg_data;

    // The pending character is processed when the buffer can take its results.
    assign pop      = head_valid && m_tready;
    assign fire     = pend_valid_reg && can_load;
    assign s_tready = !pend_valid_reg || fire;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_valid_reg <= 1'b0;
        else if (s_tready)
            pend_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
            pend_char_reg <= s_tdata;
    end

    obfr_parser u_parser
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg_wr  (cfg_wr),
        .in_fire (fire),
        .in_char (pend_char_reg),
        .burst   (burst)
    );

    obfr_outbuf u_outbuf
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (fire),
        .burst      (burst),
        .pop        (pop),
        .can_load   (can_load),
        .head_valid (head_valid),
        .head_last  (head_last),
        .head       (head)
    );

    // Output beat.
    assign m_tvalid = head_valid;
    assign m_tlast  = head_last;
    assign m_tuser  = head.is_status;
    assign m_tdata  = {5'b00000, head.frame_status, head.data_byte};

    // A character waiting for the buffer stays put.
    assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg && !fire |=> pend_valid_reg && $stable(pend_char_reg))
        else $error("pending character lost while the buffer was busy");

    // A status always closes the burst of its character.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("status beat not marked last");

    // Data beats carry a zero status code.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata[10:8] == ST_GOOD)
        else $error("data beat with a status code");

    // A loaded burst with results is presented in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && burst.count != 2'd0 |=> m_tvalid)
        else $error("loaded burst not presented");

endmodule

[dv/testbench.sv]
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import obfr_pkg::*;

    localparam int SETTLE_CYCLES    = 12;
    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int RANDOM_PER_PHASE = 10;

    // One result beat as it should leave the block.
    typedef struct packed {
        logic       is_status;
        logic [7:0] data_byte;
        logic [2:0] frame_status;
        logic       last;
    } rx_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;       // [7:0] rx_char
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;               // [7:0] data_byte, [10:8] frame_status, [15:11] zero
    logic        m_tuser;               // [0] is_status
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = 2'd0;
    logic [7:0]  cfg_data = 8'h00;

    offset_base64_frame_receiver u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock with a 4 ns period.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Character stream waiting to be sent and results still owed by the block.
    logic [7:0]  char_queue [$];
    rx_result_t  results_due [$];
    int          chars_pending = 0;
    int          chars_pushed = 0;
    int          error_count = 0;
    int          idle_cycles = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;

    // Register copies, written only when the matching beat is accepted.
    logic [7:0]  dev_addr = 8'd98;
    logic [7:0]  cmd_code = 8'd68;
    logic [7:0]  exp_len = 8'd0;

    // Receiver state as the predictor tracks it.
    phase_t      rx_phase = PH_IDLE;
    int          body_count = 0;
    logic [11:0] chk_sum = 12'h000;
    logic [7:0]  held [2] = '{8'h00, 8'h00};
    logic [7:0]  grp [3] = '{8'h00, 8'h00, 8'h00};
    int          bytes_out = 0;
    logic        use_cr = 1'b0;

    // Terminator that the stimulus side believes is current.
    logic        gen_cr = 1'b0;

    function automatic rx_result_t status_beat(input logic [2:0] code);
        rx_result_t beat;
        beat.is_status    = 1'b1;
        beat.data_byte    = 8'h00;
        beat.frame_status = code;
        beat.last         = 1'b0;
        return beat;
    endfunction

    // Work out the results of one accepted character and advance the state.
    function automatic void decode_char(input logic [7:0] c);
        rx_result_t burst [$];
        rx_result_t beat;
        logic [7:0] term;
        logic [7:0] old;
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] e;
        logic [7:0] d;
        logic [7:0] s1;
        logic [7:0] s2;
        logic [7:0] dec [3];
        logic [2:0] verdict;
        int p;
        int pos;
        int total;
        int lim;
        term = use_cr ? CH_CR : CH_LF;
        case (rx_phase)
            PH_IDLE:
            begin
                if (c == CH_START)
                begin
                    rx_phase = PH_ADDRESS;
                    body_count = 0;
                    chk_sum = 12'(CH_START);
                    bytes_out = 0;
                end
                else
                    burst.push_back(status_beat(ST_BAD_START));
            end
            PH_ADDRESS:
            begin
                if (c == dev_addr)
                begin
                    rx_phase = PH_COMMAND;
                    body_count = 1;
                    chk_sum = chk_sum + 12'(c);
                end
                else
                begin
                    burst.push_back(status_beat(ST_BAD_ADDR));
                    rx_phase = PH_IDLE;
                end
            end
            PH_COMMAND:
            begin
                if (c == cmd_code)
                begin
                    rx_phase = PH_PAYLOAD;
                    body_count = 2;
                    chk_sum = chk_sum + 12'(c);
                end
                else
                begin
                    burst.push_back(status_beat(ST_BAD_CMD));
                    rx_phase = PH_IDLE;
                end
            end
            default:
            begin
                if (c == term)
                begin
                    // Fewer than two payload characters cannot hold a checksum.
                    if (body_count < 4)
                        verdict = ST_CHECKSUM;
                    else
                    begin
                        s1 = CH_OFFSET + {2'b00, chk_sum[11:6]};
                        s2 = CH_OFFSET + {2'b00, chk_sum[5:0]};
                        total = ((body_count - 4) / 4) * 3;
                        lim = int'(exp_len);
                        if (held[0] != s1 || held[1] != s2)
                            verdict = ST_CHECKSUM;
                        else if (total >= lim && total < lim + 3)
                            verdict = ST_GOOD;
                        else
                            verdict = ST_LENGTH;
                    end
                    burst.push_back(status_beat(verdict));
                    rx_phase = PH_IDLE;
                end
                else if (body_count >= MAX_FRAME_CHARS)
                begin
                    // Overflow swaps the terminator between LF and CR.
                    use_cr = !use_cr;
                    burst.push_back(status_beat(ST_OVERFLOW));
                    rx_phase = PH_IDLE;
                end
                else
                begin
                    p = body_count - 2;
                    if (p < 2)
                        held[p] = c;
                    else
                    begin
                        // The oldest held character is now known not to be checksum.
                        old = held[0];
                        held[0] = held[1];
                        held[1] = c;
                        chk_sum = chk_sum + 12'(old);
                        pos = (p - 2) % 4;
                        if (pos < 3)
                            grp[pos] = old;
                        else
                        begin
                            a = grp[0] - CH_OFFSET;
                            b = grp[1] - CH_OFFSET;
                            e = grp[2] - CH_OFFSET;
                            d = old - CH_OFFSET;
                            dec[0] = (a << 2) | (b >> 4);
                            dec[1] = ((b & 8'h0F) << 4) | (e >> 2);
                            dec[2] = ((e & 8'h03) << 6) | d;
                            for (int i = 0; i < 3; i++)
                            begin
                                if (bytes_out < int'(exp_len))
                                begin
                                    beat.is_status    = 1'b0;
                                    beat.data_byte    = dec[i];
                                    beat.frame_status = ST_GOOD;
                                    beat.last         = 1'b0;
                                    burst.push_back(beat);
                                    bytes_out++;
                                end
                            end
                        end
                    end
                    body_count++;
                end
            end
        endcase
        if (burst.size() > 0)
            burst[burst.size() - 1].last = 1'b1;
        foreach (burst[i])
            results_due.push_back(burst[i]);
    endfunction

    // Driver: present queued characters, predicting each one as it is taken.
    always @(posedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else
        begin
            if (s_tvalid && s_tready)
            begin
                decode_char(s_tdata);
                chars_pending--;
            end
            if (!s_tvalid || s_tready)
            begin
                if (char_queue.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    s_tdata  <= char_queue.pop_front();
                    s_tvalid <= 1'b1;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: compare each result beat with the oldest prediction.
    always @(posedge clk)
    begin
        rx_result_t want;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (results_due.size() == 0)
                begin
                    $error("result beat with none due: tdata %04h tuser %b tlast %b",
                           m_tdata, m_tuser, m_tlast);
                    error_count++;
                end
                else
                begin
                    want = results_due.pop_front();
                    if (m_tuser !== want.is_status)
                    begin
                        $error("is_status mismatch: expected %0d, actual %0d",
                               want.is_status, m_tuser);
                        error_count++;
                    end
                    if (m_tdata[7:0] !== want.data_byte)
                    begin
                        $error("data_byte mismatch: expected %02h, actual %02h",
                               want.data_byte, m_tdata[7:0]);
                        error_count++;
                    end
                    if (m_tdata[10:8] !== want.frame_status)
                    begin
                        $error("frame_status mismatch: expected %0d, actual %0d",
                               want.frame_status, m_tdata[10:8]);
                        error_count++;
                    end
                    if (m_tlast !== want.last)
                    begin
                        $error("last mismatch: expected %0d, actual %0d",
                               want.last, m_tlast);
                        error_count++;
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog on cycles without any accepted beat.
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("offset_base64_frame_receiver regression: fail");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    function automatic logic [7:0] line_end();
        return gen_cr ? CH_CR : CH_LF;
    endfunction

    // Random identifier that can never be mistaken for a terminator.
    function automatic logic [7:0] random_id();
        logic [7:0] v;
        do
            v = 8'($urandom_range(255));
        while (v == CH_LF || v == CH_CR);
        return v;
    endfunction

    task automatic push_char(input logic [7:0] ch);
        char_queue.push_back(ch);
        chars_pending++;
        chars_pushed++;
    endtask

    // Queue one frame with body_len characters before the checksum. An overrun
    // frame never closes: one more character past the limit ends it instead.
    task automatic queue_frame(input int body_len, input bit bad_sum, input bit raw_bytes,
                               input bit overrun);
        logic [11:0] sum;
        logic [7:0]  ch;
        logic [7:0]  sum_hi;
        logic [7:0]  sum_lo;
        sum = 12'(CH_START) + 12'(dev_addr) + 12'(cmd_code);
        push_char(CH_START);
        push_char(dev_addr);
        push_char(cmd_code);
        repeat (body_len)
        begin
            if (raw_bytes && $urandom_range(3) == 0)
            begin
                do
                    ch = 8'($urandom_range(255));
                while (ch == line_end());
            end
            else
                ch = CH_OFFSET + 8'($urandom_range(63));
            sum = sum + 12'(ch);
            push_char(ch);
        end
        if (overrun)
        begin
            push_char(CH_OFFSET);
            gen_cr = !gen_cr;
        end
        else
        begin
            sum_hi = CH_OFFSET + {2'b00, sum[11:6]};
            sum_lo = CH_OFFSET + {2'b00, sum[5:0]};
            if (bad_sum)
                sum_lo = sum_lo ^ (8'h01 << $urandom_range(5));
            push_char(sum_hi);
            push_char(sum_lo);
            push_char(line_end());
        end
    endtask

    // Mostly well-formed frames, sized near the length register when it is small, plus noise
    // and broken frames. Every sequence leaves the receiver waiting for '#'.
    task automatic queue_random_traffic(input int count);
        int start;
        int pick;
        int target;
        int groups;
        int body;
        logic [7:0] ch;
        start = chars_pushed;
        while (chars_pushed - start < count)
        begin
            pick = $urandom_range(99);
            target = (int'(exp_len) + 2) / 3;
            if (target > 4)
                target = $urandom_range(3);
            groups = target;
            if ($urandom_range(3) == 0)
                groups = (groups > 0 && $urandom_range(1) == 1) ? groups - 1 : groups + 1;
            body = 4 * groups;
            if ($urandom_range(3) == 0)
                body += $urandom_range(1, 3);
            if (pick < 60)
                queue_frame(body, 1'b0, 1'b0, 1'b0);
            else if (pick < 70)
                queue_frame(body, 1'b1, 1'b0, 1'b0);
            else if (pick < 76)
                queue_frame(body, 1'b0, 1'b1, 1'b0);
            else if (pick < 84)
            begin
                // Line noise, closed by a terminator so the receiver settles.
                repeat ($urandom_range(1, 4))
                    push_char(8'($urandom_range(255)));
                push_char(line_end());
            end
            else if (pick < 90)
            begin
                push_char(CH_START);
                do
                    ch = 8'($urandom_range(255));
                while (ch == dev_addr);
                push_char(ch);
            end
            else if (pick < 95)
            begin
                push_char(CH_START);
                push_char(dev_addr);
                do
                    ch = 8'($urandom_range(255));
                while (ch == cmd_code);
                push_char(ch);
            end
            else
            begin
                // Frame too short to carry a checksum.
                push_char(CH_START);
                push_char(dev_addr);
                push_char(cmd_code);
                if ($urandom_range(1) == 1)
                    push_char(CH_OFFSET + 8'($urandom_range(63)));
                push_char(line_end());
            end
        end
    endtask

    // Hold off until every character is taken and every result has come out.
    task automatic wait_drained();
        do
            @(posedge clk);
        while (chars_pending != 0 || results_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Register write; cfg_valid stays high for a following write.
    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_DEVICE_ADDRESS:  dev_addr = val;
            REG_COMMAND_CODE:    cmd_code = val;
            REG_EXPECTED_LENGTH: exp_len = val;
            default: ;
        endcase
    endtask

    // Stimulus sequence.
    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed checks under the reset register values.
        push_char(8'h00);
        push_char(8'hFF);
        push_char(CH_START);
        push_char(8'h00);
        push_char(CH_START);
        push_char(dev_addr);
        push_char(8'hFF);
        push_char(CH_START);
        push_char(dev_addr);
        push_char(cmd_code);
        push_char(line_end());
        queue_frame(0, 1'b0, 1'b0, 1'b0);
        wait_drained();

        // A start mark used as the address is an ordinary character there.
        write_reg(REG_DEVICE_ADDRESS, CH_START);
        write_reg(REG_EXPECTED_LENGTH, 8'd3);
        cfg_valid <= 1'b0;
        queue_frame(4, 1'b0, 1'b0, 1'b0);
        wait_drained();

        // Low extremes, no idling.
        write_reg(REG_DEVICE_ADDRESS, 8'h00);
        write_reg(REG_COMMAND_CODE, 8'hFF);
        write_reg(REG_EXPECTED_LENGTH, 8'd0);
        cfg_valid <= 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        queue_random_traffic(RANDOM_PER_PHASE);
        wait_drained();

        // High extremes with a sparse sender: an overflowing frame delivers the
        // most bytes and moves the terminator to CR.
        write_reg(REG_DEVICE_ADDRESS, 8'hFF);
        write_reg(REG_COMMAND_CODE, 8'h00);
        write_reg(REG_EXPECTED_LENGTH, 8'd189);
        cfg_valid <= 1'b0;
        send_idle_pct = 82;
        recv_stall_pct = 0;
        queue_frame(MAX_FRAME_CHARS - 2, 1'b0, 1'b0, 1'b1);
        queue_random_traffic(RANDOM_PER_PHASE);
        wait_drained();

        // Start mark as the command, with a stalling receiver.
        write_reg(REG_DEVICE_ADDRESS, random_id());
        write_reg(REG_COMMAND_CODE, CH_START);
        write_reg(REG_EXPECTED_LENGTH, 8'($urandom_range(1, 12)));
        cfg_valid <= 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 82;
        queue_random_traffic(RANDOM_PER_PHASE);
        wait_drained();

        // Random settings with both sides idling.
        write_reg(REG_DEVICE_ADDRESS, random_id());
        write_reg(REG_COMMAND_CODE, random_id());
        write_reg(REG_EXPECTED_LENGTH, 8'($urandom_range(0, 12)));
        cfg_valid <= 1'b0;
        send_idle_pct = 26;
        recv_stall_pct = 26;
        queue_random_traffic(RANDOM_PER_PHASE);
        wait_drained();

        if (results_due.size() != 0)
        begin
            $error("%0d predicted results never arrived", results_due.size());
            error_count++;
        end
        if (error_count == 0)
            $display("offset_base64_frame_receiver regression: pass");
        else
            $display("offset_base64_frame_receiver regression: fail");
        $finish;
    end

endmodule
